// ===== hdl/rbe_pkg.sv =====
// Shared constants, state codes and interface types of the run-length byte encoder.
`timescale 1ns / 1ps

package rbe_pkg;

   localparam int MAX_RUN            = 127;
   localparam int STORE_DEPTH        = 128;
   localparam int RUN_W              = $clog2(STORE_DEPTH);
   localparam int LA_W               = 2;
   localparam int RUN_START          = 3;
   localparam int OUT_BYTES_PER_WORD = 8;
   localparam int LANE_W             = $clog2(OUT_BYTES_PER_WORD);
   localparam int CNT_W              = 4;
   localparam int WORD_W             = 64;
   localparam int REQ_DATA_W         = 8;
   localparam int RSP_DATA_W         = ((WORD_W + CNT_W + 7) / 8) * 8;

   localparam logic [RUN_W-1:0] MAX_RUN_V   = RUN_W'(MAX_RUN);
   localparam logic [RUN_W-1:0] RUN_START_V = RUN_W'(RUN_START);
   localparam logic [CNT_W-1:0] WORD_FULL_V = CNT_W'(OUT_BYTES_PER_WORD);
   localparam logic             SHORT_RUN   = (MAX_RUN <= RUN_START);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DEFER,
      ST_FIN,
      ST_HDR,
      ST_VAL,
      ST_DATA,
      ST_FLUSH
   } rbe_state_type;

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] byte_data;
      logic       flush;
      logic       stream_end;
   } rbe_pack_req_type;

   typedef struct packed {
      logic byte_ready;
      logic flush_done;
   } rbe_pack_rsp_type;

endpackage

// ===== hdl/rbe_store.sv =====
// Pending byte store: one write port and one registered read port.
`timescale 1ns / 1ps

module rbe_store (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [rbe_pkg::RUN_W-1:0] wr_addr,
   input  logic [7:0]               wr_data,
   input  logic                     rd_en,
   input  logic [rbe_pkg::RUN_W-1:0] rd_addr,
   output logic [7:0]               rd_data
);
   import rbe_pkg::*;

   logic [7:0] mem [STORE_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/rbe_packer.sv =====
// Byte packer that gathers code bytes into words and holds the output register.
`timescale 1ns / 1ps

module rbe_packer (
   input  logic                            clock,
   input  logic                            reset,
   input  rbe_pkg::rbe_pack_req_type       pk_req,
   output rbe_pkg::rbe_pack_rsp_type       pk_rsp,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rbe_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tlast,
   output logic                            rsp_tuser
);
   import rbe_pkg::*;

   logic [WORD_W-1:0] pack_ff, pack_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              out_valid_ff, out_valid_in;
   logic [WORD_W-1:0] out_word_ff, out_word_in;
   logic [CNT_W-1:0]  out_cnt_ff, out_cnt_in;
   logic              out_last_ff, out_last_in;
   logic              out_end_ff, out_end_in;
   logic              out_free;
   logic              full;
   logic [LANE_W-1:0] lane;

   assign out_free = !out_valid_ff || rsp_tready;
   assign full     = (cnt_ff == WORD_FULL_V);
   assign lane     = cnt_ff[LANE_W-1:0];

   assign pk_rsp.byte_ready = !full || out_free;
   assign pk_rsp.flush_done = pk_req.flush && ((cnt_ff == '0) || out_free);

   always_comb begin
      pack_in      = pack_ff;
      cnt_in       = cnt_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_word_in  = out_word_ff;
      out_cnt_in   = out_cnt_ff;
      out_last_in  = out_last_ff;
      out_end_in   = out_end_ff;
      if (pk_req.byte_valid && pk_rsp.byte_ready) begin
         if (full) begin
            out_valid_in = 1'b1;
            out_word_in  = pack_ff;
            out_cnt_in   = cnt_ff;
            out_last_in  = 1'b0;
            out_end_in   = 1'b0;
            pack_in      = '0;
            pack_in[7:0] = pk_req.byte_data;
            cnt_in       = CNT_W'(1);
         end else begin
            pack_in[{lane, 3'b000} +: 8] = pk_req.byte_data;
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end else if (pk_req.flush && (cnt_ff != '0) && out_free) begin
         out_valid_in = 1'b1;
         out_word_in  = pack_ff;
         out_cnt_in   = cnt_ff;
         out_last_in  = 1'b1;
         out_end_in   = pk_req.stream_end;
         pack_in      = '0;
         cnt_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pack_ff      <= '0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pack_ff      <= pack_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff <= out_word_in;
      out_cnt_ff  <= out_cnt_in;
      out_last_ff <= out_last_in;
      out_end_ff  <= out_end_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - WORD_W - CNT_W)'(0), out_cnt_ff, out_word_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_end_ff;

endmodule

// ===== hdl/rle_byte_encoder.sv =====
// Top level of the run-length byte encoder with its run control sequencer.
`timescale 1ns / 1ps
//
// The req channel carries one source byte per item, with tlast set on the final
// byte of a stream. The rsp channel carries up to eight code bytes per item,
// first byte in the lowest lane, with the valid byte count above them; tlast
// marks the last item caused by one input byte and tuser the end of the stream.
// A byte that only extends a run or the lookahead leaves the sequencer idle
// unless tlast is set. A byte that closes a run is accepted, then its code
// bytes are packed (headers, repeat bytes and literal bytes read one a cycle,
// while the packer is ready, from the single read port of the 128-entry
// pending store); then follow the new byte's lookahead write if a repeat
// pattern closed a literal, the end of stream check if tlast is set, and the
// final partial word's move to the output register. At most 129 code bytes
// follow from one input byte. Reset clears the run state; the store contents
// are left as they are and are never read before they are written. When the
// receiver stalls, the output register holds its item, the packer stops, and
// no new input is taken until the current item's results are all packed.
module rle_byte_encoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [rbe_pkg::REQ_DATA_W-1:0]  req_tdata,  // in_byte [7:0]
   input  logic                            req_tlast,  // stream_last
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [rbe_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // out_bytes [63:0], byte_count [67:64]
   output logic                            rsp_tlast,  // burst_last
   output logic                            rsp_tuser   // stream_end
);
   import rbe_pkg::*;

   rbe_state_type    state_ff, state_in;
   rbe_state_type    ret_ff, ret_in;
   logic [7:0]       b_ff, b_in;
   logic             last_ff, last_in;
   logic [RUN_W-1:0] pend_ff, pend_in;
   logic [7:0]       rv_ff, rv_in;
   logic [RUN_W-1:0] rl_ff, rl_in;
   logic             rep_ff, rep_in;
   logic [LA_W-1:0]  la_ff, la_in;
   logic [7:0]       hist1_ff, hist1_in;
   logic [7:0]       hist2_ff, hist2_in;
   logic             seg_rep_ff, seg_rep_in;
   logic [7:0]       seg_hdr_ff, seg_hdr_in;
   logic [7:0]       seg_val_ff, seg_val_in;
   logic [RUN_W-1:0] seg_len_ff, seg_len_in;
   logic [RUN_W-1:0] idx_ff, idx_in;

   logic             seg_go;
   logic             seg_rep;
   logic [RUN_W-1:0] seg_cnt;
   logic [7:0]       seg_val;
   logic             do_fi;
   logic [7:0]       fi_byte;
   logic             fi_trip;
   logic             fi_eq;
   logic [7:0]       in_byte;
   logic [RUN_W-1:0] rl_inc;
   logic [RUN_W-1:0] pend_inc;
   logic [RUN_W-1:0] idx_inc;

   logic             mem_we;
   logic [RUN_W-1:0] mem_waddr;
   logic [7:0]       mem_wdata;
   logic             mem_re;
   logic [RUN_W-1:0] mem_raddr;
   logic [7:0]       mem_rdata;

   rbe_pack_req_type pk_req;
   rbe_pack_rsp_type pk_rsp;

   assign in_byte  = req_tdata[7:0];
   assign fi_byte  = (state_ff == ST_IDLE) ? in_byte : b_ff;
   assign fi_trip  = (la_ff == LA_W'(RUN_START - 1));
   assign fi_eq    = (hist2_ff == hist1_ff) && (hist1_ff == fi_byte);
   assign rl_inc   = rl_ff + RUN_W'(1);
   assign pend_inc = pend_ff + RUN_W'(1);
   assign idx_inc  = idx_ff + RUN_W'(1);

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      b_in       = b_ff;
      last_in    = last_ff;
      pend_in    = pend_ff;
      rv_in      = rv_ff;
      rl_in      = rl_ff;
      rep_in     = rep_ff;
      la_in      = la_ff;
      hist1_in   = hist1_ff;
      hist2_in   = hist2_ff;
      seg_rep_in = seg_rep_ff;
      seg_hdr_in = seg_hdr_ff;
      seg_val_in = seg_val_ff;
      seg_len_in = seg_len_ff;
      idx_in     = idx_ff;
      seg_go     = 1'b0;
      seg_rep    = 1'b0;
      seg_cnt    = '0;
      seg_val    = '0;
      do_fi      = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = pend_ff;
      mem_wdata  = in_byte;
      mem_re     = 1'b0;
      mem_raddr  = '0;
      pk_req     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               b_in     = in_byte;
               last_in  = req_tlast;
               state_in = req_tlast ? ST_FIN : ST_IDLE;
               ret_in   = req_tlast ? ST_FIN : ST_FLUSH;
               if (rep_ff) begin
                  if (in_byte == rv_ff) begin
                     if (rl_inc >= MAX_RUN_V) begin
                        seg_go  = 1'b1;
                        seg_rep = 1'b1;
                        seg_cnt = MAX_RUN_V;
                        seg_val = rv_ff;
                        rep_in  = 1'b0;
                        rl_in   = '0;
                     end else begin
                        rl_in = rl_inc;
                     end
                  end else begin
                     seg_go  = 1'b1;
                     seg_rep = 1'b1;
                     seg_cnt = rl_ff;
                     seg_val = rv_ff;
                     rep_in  = 1'b0;
                     rl_in   = '0;
                     do_fi   = 1'b1;
                  end
               end else if (pend_ff != '0) begin
                  if ((hist2_ff == hist1_ff) && (in_byte == hist1_ff)) begin
                     seg_go  = 1'b1;
                     seg_cnt = pend_ff;
                     pend_in = '0;
                     ret_in  = ST_DEFER;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = pend_ff;
                     mem_wdata = in_byte;
                     hist2_in  = hist1_ff;
                     hist1_in  = in_byte;
                     pend_in   = pend_inc;
                     if (pend_inc >= MAX_RUN_V) begin
                        seg_go  = 1'b1;
                        seg_cnt = MAX_RUN_V;
                        pend_in = '0;
                     end
                  end
               end else begin
                  do_fi = 1'b1;
               end
            end
         end
         ST_DEFER: begin
            do_fi    = 1'b1;
            state_in = last_ff ? ST_FIN : ST_FLUSH;
            ret_in   = last_ff ? ST_FIN : ST_FLUSH;
         end
         ST_FIN: begin
            state_in = ST_FLUSH;
            ret_in   = ST_FLUSH;
            if (rep_ff) begin
               seg_go  = 1'b1;
               seg_rep = 1'b1;
               seg_cnt = rl_ff;
               seg_val = rv_ff;
               rep_in  = 1'b0;
               rl_in   = '0;
            end else if (pend_ff != '0) begin
               seg_go  = 1'b1;
               seg_cnt = pend_ff;
               pend_in = '0;
            end else if (la_ff != '0) begin
               seg_go  = 1'b1;
               seg_cnt = RUN_W'(la_ff);
               la_in   = '0;
            end
         end
         ST_HDR: begin
            pk_req.byte_valid = 1'b1;
            pk_req.byte_data  = seg_hdr_ff;
            if (pk_rsp.byte_ready) begin
               if (seg_rep_ff) begin
                  state_in = ST_VAL;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = '0;
                  idx_in    = '0;
                  state_in  = ST_DATA;
               end
            end
         end
         ST_VAL: begin
            pk_req.byte_valid = 1'b1;
            pk_req.byte_data  = seg_val_ff;
            if (pk_rsp.byte_ready) begin
               state_in = ret_ff;
            end
         end
         ST_DATA: begin
            pk_req.byte_valid = 1'b1;
            pk_req.byte_data  = mem_rdata;
            if (pk_rsp.byte_ready) begin
               if (idx_inc == seg_len_ff) begin
                  state_in = ret_ff;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = idx_inc;
                  idx_in    = idx_inc;
               end
            end
         end
         ST_FLUSH: begin
            pk_req.flush      = 1'b1;
            pk_req.stream_end = last_ff;
            if (pk_rsp.flush_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A new byte joins the lookahead; the third one decides the next run.
      if (do_fi) begin
         mem_we    = 1'b1;
         mem_waddr = RUN_W'(la_ff);
         mem_wdata = fi_byte;
         hist2_in  = hist1_ff;
         hist1_in  = fi_byte;
         if (!fi_trip) begin
            la_in = la_ff + LA_W'(1);
         end else begin
            la_in = '0;
            if (fi_eq) begin
               rep_in = 1'b1;
               rv_in  = fi_byte;
               rl_in  = RUN_START_V;
               if (SHORT_RUN) begin
                  seg_go  = 1'b1;
                  seg_rep = 1'b1;
                  seg_cnt = RUN_START_V;
                  seg_val = fi_byte;
                  rep_in  = 1'b0;
                  rl_in   = '0;
               end
            end else begin
               pend_in = RUN_START_V;
               if (SHORT_RUN) begin
                  seg_go  = 1'b1;
                  seg_cnt = RUN_START_V;
                  pend_in = '0;
               end
            end
         end
      end

      if (seg_go) begin
         seg_rep_in = seg_rep;
         seg_hdr_in = {seg_rep, seg_cnt};
         seg_val_in = seg_val;
         seg_len_in = seg_cnt;
         state_in   = ST_HDR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_FLUSH;
         pend_ff  <= '0;
         rl_ff    <= '0;
         rep_ff   <= 1'b0;
         la_ff    <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         pend_ff  <= pend_in;
         rl_ff    <= rl_in;
         rep_ff   <= rep_in;
         la_ff    <= la_in;
      end
   end

   always_ff @(posedge clock) begin
      b_ff       <= b_in;
      last_ff    <= last_in;
      rv_ff      <= rv_in;
      hist1_ff   <= hist1_in;
      hist2_ff   <= hist2_in;
      seg_rep_ff <= seg_rep_in;
      seg_hdr_ff <= seg_hdr_in;
      seg_val_ff <= seg_val_in;
      seg_len_ff <= seg_len_in;
      idx_ff     <= idx_in;
   end

   rbe_store u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   rbe_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .pk_req     (pk_req),
      .pk_rsp     (pk_rsp),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
